>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/adcc_pkg.sv
`timescale 1ns / 1ps

package adcc_pkg;

    localparam int CHANNELS  = 8;
    localparam int VOLT_BITS = 12;
    localparam int NUM_W     = VOLT_BITS + 11;
    localparam int DEN_W     = VOLT_BITS + 1;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int BIT_ADON = 0;
    localparam int BIT_ADIF = 1;
    localparam int BIT_GO   = 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ACQ  = 2'd1,
        PH_CONV = 2'd2
    } t_phase;

endpackage

>>> rtl/adc_control_and_conversion.sv
`timescale 1ns / 1ps
// A transaction that needs no division returns its result in the cycle after acceptance.
// A write that starts acquisition, the end of acquisition and the end of conversion run the
// bit-serial divider, one quotient bit per cycle; the result is registered on its done pulse.
// Throughput: one plain tick per cycle while results are taken; none while the divider runs.
// Reset: synchronous, active low; clears control, phase, counters, held samples and results.

module adc_control_and_conversion import adcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [7:0]           i_write_data,
    input  logic [11:0]          i_vin,
    input  logic [11:0]          i_vref_high,
    input  logic [11:0]          i_vref_low,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_control_value,
    output logic [7:0]           o_result_high,
    output logic [7:0]           o_result_low,
    output logic                 o_irq_pulse,
    output logic [1:0]           o_phase,
    output logic [2:0]           o_selected_channel
);

    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_CLK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_JUST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RES_BITS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CPI        = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RC_TAD     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PIR   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG     = CFG_IDX_W'(6);

    typedef enum logic {
        ST_READY,
        ST_DIV
    } t_state;

    logic                 r_extra_clk;
    logic                 r_right_just;
    logic [3:0]           r_res_bits;
    logic [2:0]           r_cpi;
    logic [7:0]           r_rc_tad;
    logic                 r_flag_in_pir;
    logic [7:0]           r_analog_mask;

    t_state               r_state;
    logic                 r_out_valid;
    logic                 r_kind_res;
    logic [7:0]           r_ctrl;
    t_phase               r_phase;
    logic [CNT_W-1:0]     r_cnt;
    logic [7:0]           r_tad;
    logic [VOLT_BITS-1:0] r_held_vin;
    logic [VOLT_BITS-1:0] r_held_hi;
    logic [VOLT_BITS-1:0] r_held_lo;
    logic [7:0]           r_res_hi;
    logic [7:0]           r_res_lo;
    logic                 r_irq;

    logic                 w_accept;
    logic                 w_go_rise;
    logic                 w_start_wr;
    logic                 w_acq_end;
    logic                 w_conv_end;
    logic                 w_need_div;
    logic                 w_analog;
    logic [2:0]           w_chan;
    logic [7:0]           w_tad_new;
    logic [CNT_W-1:0]     w_cnt_dec;
    logic [CNT_W-1:0]     w_cnt_sat;
    logic [1:0]           w_off;
    logic [2:0]           w_cpi;
    logic [9:0]           w_scale;
    logic [11:0]          w_tad_bits;
    logic [VOLT_BITS-1:0] w_diff;
    logic [VOLT_BITS-1:0] w_span;
    logic [NUM_W-1:0]     w_shifted;
    logic [NUM_W-1:0]     w_sd;
    logic [NUM_W-1:0]     w_num;
    logic [NUM_W-1:0]     w_dividend;
    logic [DEN_W-1:0]     w_divisor;
    logic [9:0]           w_code;
    logic [NUM_W-1:0]     w_quo;
    logic                 w_div_done;

    function automatic logic [7:0] pick_tad(input logic [1:0] sel, input logic extra,
                                            input logic [7:0] rc);
        logic [7:0] base;
        begin
            base = 8'd2;
            unique case (sel)
                2'd0: base = 8'd2;
                2'd1: base = 8'd8;
                2'd2: base = 8'd32;
                2'd3: base = (rc < 8'd2) ? 8'd2 : rc;
                default: base = 8'd2;
            endcase
            if (sel != 2'd3 && extra) begin
                base = {base[6:0], 1'b0};
            end
            return base;
        end
    endfunction

    always_comb begin
        w_off      = (r_res_bits < 4'd8) ? 2'd0 : ((r_res_bits > 4'd10) ? 2'd2 : r_res_bits[1:0]);
        w_cpi      = (r_cpi == 3'd0) ? 3'd1 : r_cpi;
        unique case (w_off)
            2'd0:    w_scale = 10'h0ff;
            2'd1:    w_scale = 10'h1ff;
            default: w_scale = 10'h3ff;
        endcase

        w_accept   = i_in_valid && o_in_ready;
        w_tad_new  = pick_tad(i_write_data[7:6], r_extra_clk, r_rc_tad);
        w_go_rise  = i_write_data[BIT_GO] && !r_ctrl[BIT_GO];
        w_start_wr = i_mode && i_write_data[BIT_ADON] && w_go_rise;
        w_cnt_dec  = (r_cnt != '0) ? (r_cnt - CNT_W'(1)) : r_cnt;
        w_acq_end  = !i_mode && (r_phase == PH_ACQ) && (w_cnt_dec == '0);
        w_conv_end = !i_mode && (r_phase == PH_CONV) && (w_cnt_dec == '0);
        w_need_div = w_start_wr || w_acq_end || w_conv_end;

        w_chan     = r_ctrl[5:3];
        w_analog   = ({1'b0, w_chan} < 4'(CHANNELS)) && r_analog_mask[w_chan];

        w_tad_bits = {1'b0, r_tad, 3'b000}
                   + (w_off[0] ? {4'b0000, r_tad} : 12'd0)
                   + (w_off[1] ? {3'b000, r_tad, 1'b0} : 12'd0);

        w_diff     = r_held_vin - r_held_lo;
        w_span     = r_held_hi - r_held_lo;
        w_shifted  = NUM_W'(w_diff) << (4'd8 + {2'b00, w_off});
        w_sd       = w_shifted - NUM_W'(w_diff);
        w_num      = {w_sd[NUM_W-2:0], 1'b0} + NUM_W'(w_span);

        priority if (w_conv_end) begin
            w_dividend = w_num;
            w_divisor  = {w_span, 1'b0};
        end else if (w_acq_end) begin
            w_dividend = NUM_W'(w_tad_bits);
            w_divisor  = DEN_W'(w_cpi);
        end else begin
            w_dividend = NUM_W'({w_tad_new, 1'b0});
            w_divisor  = DEN_W'(w_cpi);
        end

        w_cnt_sat  = (|w_quo[NUM_W-1:CNT_W]) ? CNT_MAX : w_quo[CNT_W-1:0];

        priority if (r_held_hi <= r_held_lo || r_held_vin <= r_held_lo) begin
            w_code = 10'd0;
        end else if (r_held_vin >= r_held_hi) begin
            w_code = w_scale;
        end else begin
            w_code = w_quo[9:0];
        end
    end

    adcc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_need_div),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra_clk   <= 1'b0;
            r_right_just  <= 1'b0;
            r_res_bits    <= 4'd10;
            r_cpi         <= 3'd4;
            r_rc_tad      <= 8'd6;
            r_flag_in_pir <= 1'b1;
            r_analog_mask <= 8'hff;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXTRA_CLK:  r_extra_clk   <= i_cfg_data[0];
                CFG_RIGHT_JUST: r_right_just  <= i_cfg_data[0];
                CFG_RES_BITS:   r_res_bits    <= i_cfg_data[3:0];
                CFG_CPI:        r_cpi         <= i_cfg_data[2:0];
                CFG_RC_TAD:     r_rc_tad      <= i_cfg_data;
                CFG_FLAG_PIR:   r_flag_in_pir <= i_cfg_data[0];
                CFG_ANALOG:     r_analog_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_out_valid <= 1'b0;
            r_kind_res  <= 1'b0;
            r_ctrl      <= '0;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_tad       <= '0;
            r_held_vin  <= '0;
            r_held_hi   <= '0;
            r_held_lo   <= '0;
            r_res_hi    <= '0;
            r_res_lo    <= '0;
            r_irq       <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_READY: begin
                    if (w_accept) begin
                        r_irq      <= 1'b0;
                        r_kind_res <= w_conv_end;
                        if (w_need_div) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                        if (i_mode) begin
                            r_tad  <= w_tad_new;
                            r_ctrl <= i_write_data;
                            if (!i_write_data[BIT_ADON]) begin
                                r_phase <= PH_IDLE;
                            end else if (w_go_rise) begin
                                r_phase <= PH_ACQ;
                            end
                        end else if (r_phase != PH_IDLE) begin
                            r_cnt <= w_cnt_dec;
                            if (w_acq_end) begin
                                r_held_vin <= w_analog ? i_vin[VOLT_BITS-1:0] : '0;
                                r_held_hi  <= i_vref_high[VOLT_BITS-1:0];
                                r_held_lo  <= i_vref_low[VOLT_BITS-1:0];
                                r_phase    <= PH_CONV;
                            end else if (w_conv_end) begin
                                r_ctrl[BIT_GO] <= 1'b0;
                                if (!r_flag_in_pir) begin
                                    r_ctrl[BIT_ADIF] <= 1'b1;
                                end
                                r_irq   <= 1'b1;
                                r_phase <= PH_IDLE;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state     <= ST_READY;
                        r_out_valid <= 1'b1;
                        if (!r_kind_res) begin
                            r_cnt <= w_cnt_sat;
                        end else if (w_off == 2'd0) begin
                            r_res_hi <= w_code[7:0];
                        end else if (r_right_just) begin
                            r_res_lo <= w_code[7:0];
                            r_res_hi <= {6'b000000, w_code[9:8]};
                        end else begin
                            r_res_lo <= {w_code[1:0], 6'b000000};
                            r_res_hi <= w_code[9:2];
                        end
                    end
                end
                default: r_state <= ST_READY;
            endcase
        end
    end

    assign o_in_ready         = (r_state == ST_READY) && (!r_out_valid || i_out_ready);
    assign o_out_valid        = r_out_valid;
    assign o_control_value    = r_ctrl;
    assign o_result_high      = r_res_hi;
    assign o_result_low       = r_res_lo;
    assign o_irq_pulse        = r_irq;
    assign o_phase            = r_phase;
    assign o_selected_channel = r_ctrl[5:3];

endmodule

>>> rtl/adcc_div.sv
`timescale 1ns / 1ps

module adcc_div import adcc_pkg::*; #(
    parameter int NUM_W = adcc_pkg::NUM_W,
    parameter int DEN_W = adcc_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_take;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_take  = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_take ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_quo  <= {r_quo[NUM_W-2:0], w_take};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/adcc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adcc_checker import adcc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [7:0]           i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_mode,
    input logic [7:0]           i_write_data,
    input logic [11:0]          i_vin,
    input logic [11:0]          i_vref_high,
    input logic [11:0]          i_vref_low,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [7:0]           o_control_value,
    input logic [7:0]           o_result_high,
    input logic [7:0]           o_result_low,
    input logic                 o_irq_pulse,
    input logic [1:0]           o_phase,
    input logic [2:0]           o_selected_channel
);

    `ASSERT_SAME(a_irq_idle, i_clk, i_rst_n, o_out_valid && o_irq_pulse, o_phase == PH_IDLE)
    `ASSERT_SAME(a_irq_go_clear, i_clk, i_rst_n, o_out_valid && o_irq_pulse, !o_control_value[BIT_GO])
    `ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, o_in_ready && o_out_valid, i_out_ready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_high) && $stable(o_control_value))

endmodule

bind adc_control_and_conversion adcc_checker u_adcc_checker (.*);

>>> sim/adc_control_and_conversion_tb.sv
`timescale 1ns / 1ps

module adc_control_and_conversion_tb;
    import adcc_pkg::*;

    localparam int TOTAL_ITEMS    = 1850;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_IDLE       = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_REGS       = 7;
    localparam int MAX_REPORTS    = 50;
    localparam int VOLT_MAX       = (1 << VOLT_BITS) - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTRA_SEL,
        REG_RIGHT_JUST,
        REG_RES_BITS,
        REG_CPI,
        REG_RC_TAD,
        REG_FLAG_PIR,
        REG_ANALOG_MASK
    } adc_reg_e;

    typedef enum logic {
        MODE_TICK,
        MODE_WRITE
    } req_mode_e;

    typedef enum logic [1:0] {
        CS_DIV2,
        CS_DIV8,
        CS_DIV32,
        CS_RC
    } clk_sel_e;

    typedef struct packed {
        req_mode_e   mode;
        logic [7:0]  write_data;
        logic [11:0] vin;
        logic [11:0] vref_high;
        logic [11:0] vref_low;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [7:0] res_high;
        logic [7:0] res_low;
        logic       irq;
        t_phase     phase;
        logic [2:0] channel;
    } adc_status_t;

    class adc_scoreboard;
        logic       extra_sel;
        logic       right_just;
        logic [3:0] res_bits;
        logic [2:0] cpi;
        logic [7:0] rc_tad;
        logic       flag_pir;
        logic [7:0] analog_mask;

        logic [7:0]       ctrl;
        t_phase           phase;
        logic [CNT_W-1:0] countdown;
        logic [7:0]       tad;
        logic [11:0]      held_vin;
        logic [11:0]      held_hi;
        logic [11:0]      held_lo;
        logic [7:0]       res_high;
        logic [7:0]       res_low;

        adc_status_t pending_status[$];
        int errors;
        int checked;
        int conversions;

        function new();
            extra_sel   = 1'b0;
            right_just  = 1'b0;
            res_bits    = 4'd10;
            cpi         = 3'd4;
            rc_tad      = 8'd6;
            flag_pir    = 1'b1;
            analog_mask = 8'hff;
            ctrl        = '0;
            phase       = PH_IDLE;
            countdown   = '0;
            tad         = '0;
            held_vin    = '0;
            held_hi     = '0;
            held_lo     = '0;
            res_high    = '0;
            res_low     = '0;
            errors      = 0;
            checked     = 0;
            conversions = 0;
        endfunction

        function void set_register(adc_reg_e idx, logic [7:0] value);
            case (idx)
                REG_EXTRA_SEL:   extra_sel   = value[0];
                REG_RIGHT_JUST:  right_just  = value[0];
                REG_RES_BITS:    res_bits    = value[3:0];
                REG_CPI:         cpi         = value[2:0];
                REG_RC_TAD:      rc_tad      = value;
                REG_FLAG_PIR:    flag_pir    = value[0];
                REG_ANALOG_MASK: analog_mask = value;
                default: ;
            endcase
        endfunction

        function int unsigned resolution();
            if (res_bits < 4'd8) return 8;
            if (res_bits > 4'd10) return 10;
            return res_bits;
        endfunction

        function logic [CNT_W-1:0] ticks_for(int unsigned periods);
            int unsigned q;
            q = periods / ((cpi == 3'd0) ? 1 : cpi);
            return (q > CNT_MAX) ? CNT_MAX : q[CNT_W-1:0];
        endfunction

        function void note_request(conv_req_t req);
            adc_status_t want;
            logic [7:0]  prev;
            logic [2:0]  chan;
            logic        irq;
            int unsigned bits_n;
            int unsigned scale;
            int unsigned span;
            logic [31:0] code;
            irq = 1'b0;
            if (req.mode == MODE_WRITE) begin
                prev = ctrl;
                case (clk_sel_e'(req.write_data[7:6]))
                    CS_DIV2:  tad = 8'd2 << extra_sel;
                    CS_DIV8:  tad = 8'd8 << extra_sel;
                    CS_DIV32: tad = 8'd32 << extra_sel;
                    default:  tad = (rc_tad < 8'd2) ? 8'd2 : rc_tad;
                endcase
                ctrl = req.write_data;
                if (!req.write_data[BIT_ADON]) begin
                    phase = PH_IDLE;
                end else if (req.write_data[BIT_GO] && !prev[BIT_GO]) begin
                    countdown = ticks_for(2 * tad);
                    phase     = PH_ACQ;
                end
            end else if (phase != PH_IDLE) begin
                if (countdown != 0) countdown--;
                if (countdown == 0) begin
                    if (phase == PH_ACQ) begin
                        chan      = ctrl[5:3];
                        held_vin  = (chan < CHANNELS && analog_mask[chan]) ? req.vin : '0;
                        held_hi   = req.vref_high;
                        held_lo   = req.vref_low;
                        countdown = ticks_for(resolution() * tad);
                        phase     = PH_CONV;
                    end else begin
                        bits_n = resolution();
                        scale  = (1 << bits_n) - 1;
                        if (held_hi <= held_lo || held_vin <= held_lo) begin
                            code = '0;
                        end else if (held_vin >= held_hi) begin
                            code = scale;
                        end else begin
                            span = held_hi - held_lo;
                            code = (2 * scale * (held_vin - held_lo) + span) / (2 * span);
                        end
                        if (bits_n > 8) begin
                            if (right_just) begin
                                res_low  = code[7:0];
                                res_high = {6'b0, code[9:8]};
                            end else begin
                                res_low  = {code[1:0], 6'b0};
                                res_high = code[9:2];
                            end
                        end else begin
                            res_high = code[7:0];
                        end
                        ctrl[BIT_GO] = 1'b0;
                        if (!flag_pir) ctrl[BIT_ADIF] = 1'b1;
                        irq   = 1'b1;
                        phase = PH_IDLE;
                        conversions++;
                    end
                end
            end
            want.ctrl     = ctrl;
            want.res_high = res_high;
            want.res_low  = res_low;
            want.irq      = irq;
            want.phase    = phase;
            want.channel  = ctrl[5:3];
            pending_status.push_back(want);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] status %0d: %s", $time, checked, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_status(adc_status_t got);
            adc_status_t want;
            checked++;
            if (pending_status.size() == 0) begin
                flag_mismatch("status returned with no transaction outstanding");
                return;
            end
            want = pending_status.pop_front();
            compare_field("control_value", got.ctrl, want.ctrl);
            compare_field("result_high", got.res_high, want.res_high);
            compare_field("result_low", got.res_low, want.res_low);
            compare_field("irq_pulse", got.irq, want.irq);
            compare_field("phase", got.phase, want.phase);
            compare_field("selected_channel", got.channel, want.channel);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_mode;
    logic [7:0]           i_write_data;
    logic [11:0]          i_vin;
    logic [11:0]          i_vref_high;
    logic [11:0]          i_vref_low;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [7:0]           o_control_value;
    logic [7:0]           o_result_high;
    logic [7:0]           o_result_low;
    logic                 o_irq_pulse;
    logic [1:0]           o_phase;
    logic [2:0]           o_selected_channel;

    adc_scoreboard sb;
    int            sent;
    logic          no_idle;

    adc_control_and_conversion dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_write_data       (i_write_data),
        .i_vin              (i_vin),
        .i_vref_high        (i_vref_high),
        .i_vref_low         (i_vref_low),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_control_value    (o_control_value),
        .o_result_high      (o_result_high),
        .o_result_low       (o_result_low),
        .o_irq_pulse        (o_irq_pulse),
        .o_phase            (o_phase),
        .o_selected_channel (o_selected_channel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] ctrl_of(clk_sel_e sel, logic [2:0] ch, logic go, logic adon);
        logic [7:0] b;
        b            = '0;
        b[7:6]       = sel;
        b[5:3]       = ch;
        b[BIT_GO]    = go;
        b[BIT_ADON]  = adon;
        return b;
    endfunction

    function automatic logic [7:0] random_ctrl(logic go, logic adon);
        logic [7:0] b;
        int         r;
        clk_sel_e   sel;
        r = $urandom_range(0, 19);
        if (r < 12) sel = CS_DIV2;
        else if (r < 17) sel = CS_DIV8;
        else if (r < 19) sel = CS_DIV32;
        else sel = CS_RC;
        b = ctrl_of(sel, $urandom_range(0, 7), go, adon);
        b[BIT_ADIF] = $urandom_range(0, 1);
        return b;
    endfunction

    function automatic conv_req_t write_req(logic [7:0] data);
        conv_req_t req;
        req.mode       = MODE_WRITE;
        req.write_data = data;
        req.vin        = $urandom_range(0, VOLT_MAX);
        req.vref_high  = $urandom_range(0, VOLT_MAX);
        req.vref_low   = $urandom_range(0, VOLT_MAX);
        return req;
    endfunction

    function automatic conv_req_t fixed_tick(logic [11:0] vin, logic [11:0] hi, logic [11:0] lo);
        conv_req_t req;
        req.mode       = MODE_TICK;
        req.write_data = $urandom_range(0, 255);
        req.vin        = vin;
        req.vref_high  = hi;
        req.vref_low   = lo;
        return req;
    endfunction

    function automatic conv_req_t tick_req();
        conv_req_t req;
        req = fixed_tick($urandom_range(0, VOLT_MAX), $urandom_range(0, VOLT_MAX),
                         $urandom_range(0, VOLT_MAX));
        case ($urandom_range(0, 9))
            0: req.vref_high = $urandom_range(0, req.vref_low);
            1: req.vin = $urandom_range(0, req.vref_low);
            2: begin
                req.vref_low = $urandom_range(0, req.vref_high);
                req.vin      = $urandom_range(req.vref_high, VOLT_MAX);
            end
            3: begin
                req.vin       = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                req.vref_high = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                req.vref_low  = $urandom_range(0, 1) ? 12'hfff : 12'h000;
            end
            4, 5: ;
            default: begin
                req.vref_low  = $urandom_range(0, VOLT_MAX / 2);
                req.vref_high = $urandom_range(req.vref_low + 1, VOLT_MAX);
            end
        endcase
        return req;
    endfunction

    task automatic send_req(input conv_req_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= req.mode;
        i_write_data <= req.write_data;
        i_vin        <= req.vin;
        i_vref_high  <= req.vref_high;
        i_vref_low   <= req.vref_low;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        sent++;
    endtask

    task automatic finish_with(logic [11:0] vin, logic [11:0] hi, logic [11:0] lo);
        while (sb.phase != PH_IDLE) send_req(fixed_tick(vin, hi, lo));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic program_settings(int phase_no);
        logic [7:0] regs [NUM_REGS];
        case (phase_no)
            0: begin
                regs[REG_EXTRA_SEL]   = 8'd1;
                regs[REG_RIGHT_JUST]  = 8'd1;
                regs[REG_RES_BITS]    = 8'd8;
                regs[REG_CPI]         = 8'd1;
                regs[REG_RC_TAD]      = 8'd2;
                regs[REG_FLAG_PIR]    = 8'd0;
                regs[REG_ANALOG_MASK] = 8'h00;
            end
            1: begin
                regs[REG_EXTRA_SEL]   = 8'd0;
                regs[REG_RIGHT_JUST]  = 8'd0;
                regs[REG_RES_BITS]    = 8'd10;
                regs[REG_CPI]         = 8'd4;
                regs[REG_RC_TAD]      = 8'd255;
                regs[REG_FLAG_PIR]    = 8'd1;
                regs[REG_ANALOG_MASK] = 8'hff;
            end
            2: begin
                regs[REG_EXTRA_SEL]   = 8'd1;
                regs[REG_RIGHT_JUST]  = 8'd1;
                regs[REG_RES_BITS]    = 8'd0;
                regs[REG_CPI]         = 8'd0;
                regs[REG_RC_TAD]      = 8'd0;
                regs[REG_FLAG_PIR]    = 8'd0;
                regs[REG_ANALOG_MASK] = 8'h5a;
            end
            default: begin
                regs[REG_EXTRA_SEL]   = $urandom_range(0, 1);
                regs[REG_RIGHT_JUST]  = $urandom_range(0, 1);
                regs[REG_RES_BITS]    = ($urandom_range(0, 9) < 8) ? $urandom_range(8, 10)
                                                                   : $urandom_range(0, 15);
                regs[REG_CPI]         = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                                   : $urandom_range(0, 7);
                regs[REG_RC_TAD]      = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24)
                                                                   : $urandom_range(0, 255);
                regs[REG_FLAG_PIR]    = $urandom_range(0, 1);
                regs[REG_ANALOG_MASK] = ($urandom_range(0, 4) == 0) ? 8'hff
                                                                    : $urandom_range(0, 255);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[CFG_IDX_W-1:0];
            i_cfg_data <= regs[i];
            @(posedge i_clk);
            sb.set_register(adc_reg_e'(i), regs[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_conversion();
        int pick;
        if (sb.phase == PH_IDLE) begin
            if (sb.ctrl[BIT_GO]) send_req(write_req(random_ctrl(1'b0, $urandom_range(0, 1))));
            send_req(write_req(random_ctrl(1'b1, 1'b1)));
        end
        while (sb.phase != PH_IDLE && sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) send_req(write_req(random_ctrl($urandom_range(0, 1), 1'b0)));
            else if (pick < 4) send_req(write_req(random_ctrl(1'b0, 1'b1)));
            else if (pick < 6) send_req(write_req(random_ctrl(1'b1, 1'b1)));
            else send_req(tick_req());
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) send_req(tick_req());
            else send_req(write_req($urandom_range(0, 255)));
        end
    endtask

    initial begin : status_sink
        int          stall;
        bit          held_off;
        adc_status_t got;
        i_out_ready <= 1'b0;
        held_off = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (!held_off && sb.checked >= HOLD_AFTER) begin
                stall    = HOLD_CYCLES;
                held_off = 1'b1;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.ctrl     = o_control_value;
            got.res_high = o_result_high;
            got.res_low  = o_result_low;
            got.irq      = o_irq_pulse;
            got.phase    = t_phase'(o_phase);
            got.channel  = o_selected_channel;
            sb.check_status(got);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a transaction", quiet);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        int phase_end;
        sb       = new();
        sent     = 0;
        no_idle  = 1'b0;
        phase_no = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_TICK;
        i_write_data <= '0;
        i_vin        <= '0;
        i_vref_high  <= '0;
        i_vref_low   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(fixed_tick(12'hfff, 12'hfff, 12'h000));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd0, 1'b1, 1'b1)));
        finish_with(12'hfff, 12'hfff, 12'h000);
        send_req(write_req(ctrl_of(CS_DIV2, 3'd3, 1'b1, 1'b1)));
        send_req(fixed_tick(12'h000, 12'h000, 12'h000));
        // abort, then GO stays high so the next write must not start
        send_req(write_req(ctrl_of(CS_DIV2, 3'd3, 1'b1, 1'b0)));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd5, 1'b1, 1'b1)));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd5, 1'b0, 1'b1)));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd5, 1'b1, 1'b1)));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd5, 1'b1, 1'b1)));
        send_req(write_req(ctrl_of(CS_DIV2, 3'd5, 1'b0, 1'b1)));
        finish_with(12'd2048, 12'd4000, 12'd100);
        send_req(write_req(ctrl_of(CS_DIV2, 3'd7, 1'b1, 1'b1)));
        finish_with(12'h000, 12'h000, 12'hfff);

        while (sent < TOTAL_ITEMS) begin
            wait_idle();
            program_settings(phase_no);
            no_idle   = (phase_no % 4 == 3);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end && sent < TOTAL_ITEMS) begin
                if ($urandom_range(0, 3) == 0) noise_burst();
                run_conversion();
            end
            phase_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d transactions under %0d register settings, %0d conversions done.",
                 sent, phase_no + 1, sb.conversions);
        $display("Status words checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
